/* rtl/hcbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_SYMBOLS      = 256;

    localparam int CODE_W  = 32;   // stored code word width
    localparam int LEN_W   = 6;    // stored code length width
    localparam int BYTE_W  = 8;
    localparam int MAX_OUT = 4;    // most bytes one encode can complete
    localparam int ACC_W   = 39;   // 7 pending bits + 32 code bits
    localparam int WIN_W   = 40;   // left-aligned byte window

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    // One item's worth of output beats
    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [1:0]                     last_idx;
        logic                           byte_valid;
        logic [2:0]                     trash;
        logic                           is_final;
    } pkt_t;

endpackage

/* rtl/hcbp_code_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code table RAM: clips and masks loaded codes, registered read.
// ----------------------------------------------------------------------------
module hcbp_code_table #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOLS      = hcbp_pkg::DEF_SYMBOLS
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(SYMBOLS)-1:0]      wr_addr,
    input  logic [hcbp_pkg::CODE_W-1:0]     wr_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]      wr_len,
    input  logic                            rd_en,
    input  logic [$clog2(SYMBOLS)-1:0]      rd_addr,
    output hcbp_pkg::entry_t                rd_entry
);
    import hcbp_pkg::*;

    localparam int LenCap = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    entry_t mem [SYMBOLS];
    entry_t rd_entry_reg;
    entry_t wr_entry;
    logic [LEN_W-1:0] clip_len;

    always_comb
    begin
        clip_len = (wr_len > LEN_W'(LenCap)) ? LEN_W'(LenCap) : wr_len;
        wr_entry.len  = clip_len;
        // shift by the full width yields zero, so length 32 keeps every bit
        wr_entry.code = wr_bits & ~({CODE_W{1'b1}} << clip_len);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

/* rtl/hcbp_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_packer
// Merge stage: appends the looked-up code to the pending bits, cuts bytes.
// ----------------------------------------------------------------------------
module hcbp_packer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_go,
    input  logic             in_flush,
    input  logic             in_sym_ok,
    input  hcbp_pkg::entry_t rd_entry,
    input  logic             pkt_free,
    output logic             ready,
    output logic             pkt_load,
    output hcbp_pkg::pkt_t   pkt
);
    import hcbp_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_flush_reg;
    logic       s1_sym_ok_reg;
    logic [6:0] partial_bits_reg, partial_bits_next;
    logic [2:0] partial_count_reg, partial_count_next;

    logic [LEN_W-1:0]  eff_len;
    logic [CODE_W-1:0] eff_code;
    logic [ACC_W-1:0]  acc;
    logic [LEN_W-1:0]  total;
    logic [WIN_W-1:0]  aligned;
    logic [2:0]        nbytes;
    logic              adv;

    always_comb
    begin
        eff_len  = s1_sym_ok_reg ? rd_entry.len  : '0;
        eff_code = s1_sym_ok_reg ? rd_entry.code : '0;
        acc      = (ACC_W'(partial_bits_reg) << eff_len) | ACC_W'(eff_code);
        total    = LEN_W'(partial_count_reg) + eff_len;
        aligned  = WIN_W'(acc) << (LEN_W'(WIN_W) - total);

        pkt = '0;
        if (s1_flush_reg)
        begin
            nbytes         = 3'd1;
            pkt.is_final   = 1'b1;
            pkt.last_idx   = 2'd0;
            if (partial_count_reg != 3'd0)
            begin
                pkt.byte_valid = 1'b1;
                pkt.bytes[0]   = BYTE_W'({partial_bits_reg, 1'b0} << (3'd7 - partial_count_reg));
                pkt.trash      = 3'(4'd8 - {1'b0, partial_count_reg});
            end
            partial_bits_next  = '0;
            partial_count_next = '0;
        end
        else
        begin
            nbytes         = total[5:3];
            pkt.byte_valid = 1'b1;
            pkt.last_idx   = 2'(nbytes - 3'd1);
            for (int k = 0; k < MAX_OUT; k++)
            begin
                pkt.bytes[k] = aligned[WIN_W-1-BYTE_W*k -: BYTE_W];
            end
            partial_count_next = total[2:0];
            partial_bits_next  = acc[6:0] & ~(7'h7F << total[2:0]);
        end

        adv      = s1_valid_reg && ((nbytes == 3'd0) || pkt_free);
        pkt_load = adv && (nbytes != 3'd0);
        ready    = !s1_valid_reg || adv;
        s1_valid_next = ready ? in_go : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            partial_bits_reg  <= '0;
            partial_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (adv)
            begin
                partial_bits_reg  <= partial_bits_next;
                partial_count_reg <= partial_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_go)
        begin
            s1_flush_reg  <= in_flush;
            s1_sym_ok_reg <= in_sym_ok;
        end
    end

    // pending bits above the count stay clear
    a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_bits_reg & (7'h7F << partial_count_reg)) == 7'd0)
        else $error("pending bits above count not clear");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_flush_reg) |=> (partial_count_reg == 3'd0))
        else $error("flush left pending bits");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> s1_valid_reg)
        else $error("blocked merge stage lost its item");

endmodule

/* rtl/hcbp_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_out_queue
// Holds one item's bytes and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module hcbp_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pkt_load,
    input  hcbp_pkg::pkt_t pkt,
    output logic           pkt_free,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           byte_valid,
    output logic [2:0]     trash_bits,
    output logic           is_final,
    output logic           last
);
    import hcbp_pkg::*;

    pkt_t       pkt_reg;
    logic       pkt_valid_reg, pkt_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       fire;
    logic       last_beat;

    always_comb
    begin
        last_beat = (idx_reg == pkt_reg.last_idx);
        fire      = pkt_valid_reg && !out_stall;
        pkt_free  = !pkt_valid_reg || (fire && last_beat);

        pkt_valid_next = pkt_valid_reg;
        idx_next       = idx_reg;
        if (pkt_load)
        begin
            pkt_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (fire && last_beat)
        begin
            pkt_valid_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            pkt_valid_reg <= pkt_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_load)
        begin
            pkt_reg <= pkt;
        end
    end

    assign out_valid  = pkt_valid_reg;
    assign out_byte   = pkt_reg.bytes[idx_reg];
    assign byte_valid = pkt_reg.byte_valid;
    assign trash_bits = pkt_reg.trash;
    assign is_final   = pkt_reg.is_final;
    assign last       = last_beat;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg |-> (idx_reg <= pkt_reg.last_idx))
        else $error("beat index past end of item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_load |-> pkt_free)
        else $error("item loaded over undelivered beats");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last_beat && !pkt_load) |=> (idx_reg == $past(idx_reg) + 2'd1))
        else $error("beat index did not advance");

endmodule

/* rtl/huffman_code_bit_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Variable-length code packer: code table RAM, merge stage, output beats.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one command per beat:
//     load   - writes symbol's code word and length into the code table;
//     encode - looks the symbol up and appends its code MSB first;
//     flush  - emits the pending partial byte, zero padded, with trash count.
//   Output channel (out_valid / out_stall) carries one byte per beat; last
//   marks the final beat caused by an input beat. Loads give no beats, an
//   encode gives one beat per completed byte (0 to 4), a flush always one.
//   The table read register and the merge stage load at the accept edge;
//   the merge result then loads the output register once that register is
//   free to take it.
//   Throughput: one input beat per cycle while each item yields at most one
//   byte and out_stall is low; an item yielding k bytes holds the single
//   output register until its last byte is out, one byte per cycle unstalled.
//   A load may be followed directly by an encode of the same symbol: the
//   write lands at the accept edge, before the next read.
//   Stall: when the receiver stalls, the output register holds its beat and
//   the merge stage holds an item that has bytes, which raises in_stall.
//   Reset clears the pending bits and all handshake state; the code table is
//   not cleared and must be loaded before its entries are encoded.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOLS      = hcbp_pkg::DEF_SYMBOLS
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  symbol,
    input  logic [31:0] code_bits,
    input  logic [5:0]  code_len,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic [2:0]  trash_bits,
    output logic        is_final,
    output logic        last
);
    import hcbp_pkg::*;

    localparam int AddrW = $clog2(SYMBOLS);

    logic   accept;
    logic   sym_ok;
    logic   wr_en;
    logic   rd_en;
    logic   go;
    logic   is_flush;
    logic   ready;
    logic   pkt_load;
    logic   pkt_free;
    entry_t rd_entry;
    pkt_t   pkt;

    // Command decode at the accept edge
    always_comb
    begin
        accept   = in_valid && !in_stall;
        sym_ok   = (9'(symbol) < 9'(SYMBOLS));
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        go       = 1'b0;
        is_flush = 1'b0;
        case (cmd)
            CMD_LOAD:
            begin
                wr_en = accept && sym_ok;
            end
            CMD_ENCODE:
            begin
                rd_en = accept;
                go    = accept;
            end
            CMD_FLUSH:
            begin
                go       = accept;
                is_flush = 1'b1;
            end
            default:
            begin
                // unused code: dropped
                go = 1'b0;
            end
        endcase
    end

    assign in_stall = !ready;

    hcbp_code_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOLS      (SYMBOLS)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (symbol[AddrW-1:0]),
        .wr_bits  (code_bits),
        .wr_len   (code_len),
        .rd_en    (rd_en),
        .rd_addr  (symbol[AddrW-1:0]),
        .rd_entry (rd_entry)
    );

    hcbp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_go     (go),
        .in_flush  (is_flush),
        .in_sym_ok (sym_ok),
        .rd_entry  (rd_entry),
        .pkt_free  (pkt_free),
        .ready     (ready),
        .pkt_load  (pkt_load),
        .pkt       (pkt)
    );

    hcbp_out_queue u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_load   (pkt_load),
        .pkt        (pkt),
        .pkt_free   (pkt_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .trash_bits (trash_bits),
        .is_final   (is_final),
        .last       (last)
    );

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_final) |-> last)
        else $error("flush beat not marked last");

    a_final_trash: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_final) |-> (byte_valid && trash_bits == 3'd0))
        else $error("encode beat carries padding");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with output register empty");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Huffman code bit packer. A behavioural packer
// runs beside the core on every accepted input beat and queues the bytes it
// should produce; each output beat is checked field by field against the
// oldest queued byte. Random gaps and stalls on both channels, calm
// back-to-back stretches and one long receiver hold-off that backs the core up.
// ----------------------------------------------------------------------------
module tb_top;

    import hcbp_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int MAX_LEN     = DEF_MAX_CODE_LEN;
    localparam int SYM_N       = DEF_SYMBOLS;
    // Worst case is ~420 beats, each with a random gap and up to four bytes behind
    // random stalls, plus the long hold-off. Plenty of room.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 16;   // settle time before and after the drain

    // cmd value with no meaning; the core must swallow it silently
    localparam logic [1:0] CMD_RSVD = 2'd3;

    // One expected output beat
    typedef struct {
        logic [7:0] data;
        logic       has_data;
        logic [2:0] trash;
        logic       fin;
        logic       tail;
    } beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd       = CMD_LOAD;
    logic [7:0]  symbol    = 8'd0;
    logic [31:0] code_bits = 32'd0;
    logic [5:0]  code_len  = 6'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [2:0]  trash_bits;
    logic        is_final;
    logic        last;

    huffman_code_bit_packer_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .symbol     (symbol),
        .code_bits  (code_bits),
        .code_len   (code_len),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .trash_bits (trash_bits),
        .is_final   (is_final),
        .last       (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioural packer: own code table and bit accumulator
    // ------------------------------------------------------------------------
    logic [31:0] tbl_code [SYM_N];
    logic [5:0]  tbl_len  [SYM_N];
    logic [6:0]  acc_bits = 7'd0;   // pending bits, right aligned
    logic [2:0]  acc_cnt  = 3'd0;   // how many of them are live
    beat_t       pending_bytes [$];

    initial
    begin
        for (int i = 0; i < SYM_N; i++)
        begin
            tbl_code[i] = 32'd0;
            tbl_len[i]  = 6'd0;
        end
    end

    // Length is clipped to the core's limit and to the 32-bit code word;
    // anything above the kept length is dropped from the code.
    task automatic store_code(input logic [7:0] sym, input logic [31:0] bits,
                              input logic [5:0] len);
        logic [5:0]  n;
        logic [63:0] mask;
        n = len;
        if (n > MAX_LEN)
            n = 6'(MAX_LEN);
        if (n > 6'd32)
            n = 6'd32;
        mask = (64'd1 << n) - 64'd1;
        if (sym < SYM_N)
        begin
            tbl_code[sym] = bits & mask[31:0];
            tbl_len[sym]  = n;
        end
    endtask

    // Append the symbol's code MSB first; every whole byte goes out at once,
    // the final one of the item carrying the tail mark.
    task automatic append_code(input logic [7:0] sym);
        logic [63:0] acc;
        int          total;
        int          len;
        beat_t       b;
        len = (sym < SYM_N) ? int'(tbl_len[sym]) : 0;
        acc = (64'(acc_bits) << len) | 64'((sym < SYM_N) ? tbl_code[sym] : 32'd0);
        total = int'(acc_cnt) + len;
        while (total >= 8)
        begin
            total      -= 8;
            b.data     = 8'(acc >> total);
            b.has_data = 1'b1;
            b.trash    = 3'd0;
            b.fin      = 1'b0;
            b.tail     = (total < 8);
            pending_bytes.push_back(b);
        end
        acc_bits = 7'(acc & ((64'd1 << total) - 64'd1));
        acc_cnt  = 3'(total);
    endtask

    // Flush always yields one beat: padded partial byte, or an empty marker
    task automatic flush_partial();
        beat_t b;
        int    pad;
        if (acc_cnt != 3'd0)
        begin
            pad        = 8 - int'(acc_cnt);
            b.data     = 8'(64'(acc_bits) << pad);
            b.has_data = 1'b1;
            b.trash    = 3'(pad);
        end
        else
        begin
            b.data     = 8'd0;
            b.has_data = 1'b0;
            b.trash    = 3'd0;
        end
        b.fin    = 1'b1;
        b.tail   = 1'b1;
        acc_bits = 7'd0;
        acc_cnt  = 3'd0;
        pending_bytes.push_back(b);
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: sample both channels at the edge, pre-update values only
    // ------------------------------------------------------------------------
    int mismatches    = 0;
    int n_load        = 0;
    int n_encode      = 0;
    int n_flush       = 0;
    int n_ignored     = 0;
    int n_bytes_out   = 0;
    int in_stall_seen = 0;
    int cycles        = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        beat_t want;
        if (rst_n)
        begin
            // output side first; an expectation queued this edge cannot be due yet
            if (out_valid && !out_stall)
            begin
                n_bytes_out++;
                if (pending_bytes.size() == 0)
                    report_mismatch("unexpected beat", 32'(out_byte), 32'd0);
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
                    if (byte_valid !== want.has_data)
                        report_mismatch("byte_valid", 32'(byte_valid), 32'(want.has_data));
                    if (trash_bits !== want.trash)
                        report_mismatch("trash_bits", 32'(trash_bits), 32'(want.trash));
                    if (is_final !== want.fin)
                        report_mismatch("is_final", 32'(is_final), 32'(want.fin));
                    if (last !== want.tail)
                        report_mismatch("last", 32'(last), 32'(want.tail));
                end
            end
            if (in_valid && in_stall)
                in_stall_seen++;
            if (in_valid && !in_stall)
            begin
                case (cmd)
                    CMD_LOAD:
                    begin
                        store_code(symbol, code_bits, code_len);
                        n_load++;
                    end
                    CMD_ENCODE:
                    begin
                        append_code(symbol);
                        n_encode++;
                    end
                    CMD_FLUSH:
                    begin
                        flush_partial();
                        n_flush++;
                    end
                    default:
                        n_ignored++;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d bytes still owed",
                     cycles, pending_bytes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: per-beat random stall, calm mode, and one-off long hold-off
    // ------------------------------------------------------------------------
    bit tx_calm   = 1'b0;
    bit rx_calm   = 1'b0;
    int rx_hold   = 0;    // set by a test; taken by the receiver at its next draw
    int longest_hold = 0;

    initial
    begin : receiver
        int w;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                w       = rx_hold;
                rx_hold = 0;
            end
            else if (rx_calm)
                w = 0;
            else
                w = $urandom_range(0, 17);
            if (w > longest_hold)
                longest_hold = w;
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the edge its beat is taken,
    // leaving valid high so a zero gap gives a back-to-back beat.
    // ------------------------------------------------------------------------
    logic [7:0] known_syms [$];
    bit         sym_known  [SYM_N];

    task automatic send_item(input logic [1:0] c, input logic [7:0] s,
                             input logic [31:0] b, input logic [5:0] l);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        symbol    <= s;
        code_bits <= b;
        code_len  <= l;
        do @(posedge clk); while (in_stall);
    endtask

    // Loads are tracked here so that only written entries ever get encoded
    task automatic load_code(input logic [7:0] s, input logic [31:0] b,
                             input logic [5:0] l);
        send_item(CMD_LOAD, s, b, l);
        if (!sym_known[s])
        begin
            sym_known[s] = 1'b1;
            known_syms.push_back(s);
        end
    endtask

    // Fields not used by a command carry noise on purpose
    task automatic encode_sym(input logic [7:0] s);
        send_item(CMD_ENCODE, s, $urandom, 6'($urandom));
    endtask

    // Mostly short codes as a real tree gives; now and then long, over-long
    // or empty ones
    task automatic load_random();
        int         roll;
        logic [5:0] len;
        roll = $urandom_range(0, 63);
        if (roll < 2)
            len = 6'd0;
        else if (roll < 6)
            len = 6'($urandom_range(33, 63));
        else if (roll < 14)
            len = 6'($urandom_range(13, 32));
        else
            len = 6'($urandom_range(1, 12));
        load_code(8'($urandom_range(0, 255)), $urandom, len);
    endtask

    // A well-formed stream: loads, encodes of loaded symbols, occasional
    // flushes; reserved commands sprinkled in but not counted
    task automatic run_stream(input int n_items);
        int sent;
        int roll;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_item(CMD_RSVD, 8'($urandom), $urandom, 6'($urandom));
            else
            begin
                if (roll < 14 || known_syms.size() == 0)
                    load_random();
                else if (roll < 20)
                    send_item(CMD_FLUSH, 8'($urandom), $urandom, 6'($urandom));
                else
                    encode_sym(known_syms[$urandom_range(0, known_syms.size() - 1)]);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and every corner the packer has
    task automatic test_special_cases();
        send_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);           // empty flush
        send_item(CMD_RSVD, 8'hFF, 32'hFFFF_FFFF, 6'h3F);  // ignored command
        load_code(8'd0,   32'hFFFF_FFFF, 6'd1);            // only bit 0 kept
        load_code(8'd255, 32'hFFFF_FFFF, 6'd32);
        load_code(8'd170, 32'h0000_0000, 6'd63);           // over-long, clipped
        load_code(8'd85,  32'hDEAD_BEEF, 6'd0);            // empty code
        load_code(8'd7,   32'h1234_5655, 6'd7);
        encode_sym(8'd85);                                 // appends nothing
        encode_sym(8'd7);                                  // 7 bits, no byte yet
        encode_sym(8'd255);                                // 39 bits: four bytes
        encode_sym(8'd170);                                // again four bytes
        send_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);           // 7 pending, 1 padding
        encode_sym(8'd0);
        send_item(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F); // 1 pending, 7 padding
        load_code(8'd3, 32'hFE1A_BCDE, 6'd25);
        encode_sym(8'd7);
        encode_sym(8'd3);                                  // exactly four bytes
        send_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);           // empty again
        load_code(8'd9, 32'h0000_0005, 6'd3);              // load then use at once
        encode_sym(8'd9);
        load_code(8'd9, 32'h0000_03C3, 6'd10);             // rewrite same entry
        encode_sym(8'd9);
        send_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    endtask

    // No gaps, no stalls: full-rate beats
    task automatic test_back_to_back();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_stream(60);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Random gaps and stalls on every phase of the core's work
    task automatic test_random_stream();
        run_stream(240);
        send_item(CMD_FLUSH, 8'($urandom), $urandom, 6'($urandom));
    endtask

    // Receiver sits on the output while the sender keeps pushing
    task automatic test_backpressure();
        tx_calm = 1'b1;
        rx_hold = HOLD_CYCLES;
        run_stream(40);
        send_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
        tx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_back_to_back();
        test_random_stream();
        test_backpressure();

        // let the last accepted beat reach the scoreboard, then wait for
        // every owed byte; the watchdog catches a beat that never comes
        in_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d loads, %0d encodes, %0d flushes, %0d reserved; %0d bytes checked",
                 n_load, n_encode, n_flush, n_ignored, n_bytes_out);
        $display("Longest output hold-off %0d cycles; input held back on %0d cycles",
                 longest_hold, in_stall_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/hcbp_pkg.sv
rtl/hcbp_code_table.sv
rtl/hcbp_packer.sv
rtl/hcbp_out_queue.sv
rtl/huffman_code_bit_packer_core.sv
dv/tb_top.sv
